// ===== design/mcps_pkg.sv =====
package mcps_pkg;

    // Sizing of the sampler.
    localparam int MAX_STATES = 16;
    localparam int PROB_BITS  = 16;

    // Derived widths: state index, state count, table row (one extra row holds
    // the start vector) and the running sum, which can never wrap.
    localparam int IDX_W  = $clog2(MAX_STATES);
    localparam int CNT_W  = $clog2(MAX_STATES + 1);
    localparam int ROW_W  = $clog2(MAX_STATES + 1);
    localparam int ADDR_W = ROW_W + IDX_W;
    localparam int DEPTH  = (MAX_STATES + 1) * MAX_STATES;
    localparam int ACC_W  = PROB_BITS + IDX_W + 1;

    // Row of the table memory that holds the start vector.
    localparam logic [ROW_W-1:0] START_ROW = ROW_W'(MAX_STATES);

    // Width of the configuration register.
    localparam int CFG_W = 5;

    // Action codes of an input word.
    typedef enum logic [1:0] {
        ACT_LOAD_START = 2'd0,
        ACT_LOAD_TRANS = 2'd1,
        ACT_STEP       = 2'd2,
        ACT_FIRST      = 2'd3
    } action_t;

    // Input word.
    typedef struct packed {
        action_t              action;
        logic [3:0]           row_index;
        logic [3:0]           column_index;
        logic [PROB_BITS-1:0] probability;
        logic [PROB_BITS-1:0] uniform_sample;
    } cmd_t;

    // Result word.
    typedef struct packed {
        logic [4:0] sampled_state;
        logic       not_found;
    } result_t;

endpackage

// ===== design/markov_chain_path_sampler.sv =====
// Channel   | Ports                      | Direction | Handshake
// ----------+----------------------------+-----------+-------------------------
// command   | start, busy, cmd           | in        | taken when start && !busy
// result    | done, result               | out       | valid for the done cycle
// config    | cfg_we, cfg_wdata          | in        | written when cfg_we
//
// A load word writes the table, leaves busy low and produces no result. A
// sample word walks one table row, one entry a cycle, through the single
// table read port and one shared add-and-compare unit: busy stays high for
// the whole walk and done rises in the same cycle as busy falls.
// Reset clears the control state and the current state and sets num_states to
// MAX_STATES; the tables need no clearing pass. The receiver cannot stall.
module markov_chain_path_sampler (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  mcps_pkg::cmd_t              cmd,
    output logic                        done,
    output mcps_pkg::result_t           result,
    input  logic                        cfg_we,
    input  logic [mcps_pkg::CFG_W-1:0]  cfg_wdata
);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } state_t;

    state_t                           state_reg;
    state_t                           state_next;
    logic [mcps_pkg::CFG_W-1:0]       num_states_reg;
    logic [mcps_pkg::IDX_W-1:0]       cur_state_reg;
    logic [mcps_pkg::IDX_W-1:0]       cur_state_next;
    logic [mcps_pkg::ROW_W-1:0]       row_reg;
    logic [mcps_pkg::ROW_W-1:0]       row_next;
    logic [mcps_pkg::PROB_BITS-1:0]   u_reg;
    logic [mcps_pkg::PROB_BITS-1:0]   u_next;
    logic [mcps_pkg::IDX_W-1:0]       rd_idx_reg;
    logic [mcps_pkg::IDX_W-1:0]       rd_idx_next;
    logic [mcps_pkg::IDX_W-1:0]       cmp_idx_reg;
    logic [mcps_pkg::IDX_W-1:0]       cmp_idx_next;
    logic                             vld_reg;
    logic                             vld_next;
    logic [mcps_pkg::ACC_W-1:0]       sum_reg;
    logic [mcps_pkg::ACC_W-1:0]       sum_next;
    logic                             done_reg;
    logic                             done_next;
    mcps_pkg::result_t                result_reg;
    mcps_pkg::result_t                result_next;

    logic                             accept;
    logic                             wr_en;
    logic [mcps_pkg::ROW_W-1:0]       wr_row;
    logic [mcps_pkg::ADDR_W-1:0]      wr_addr;
    logic [mcps_pkg::ADDR_W-1:0]      rd_addr;
    logic [mcps_pkg::PROB_BITS-1:0]   rd_data;
    logic [mcps_pkg::IDX_W-1:0]       last_idx;
    logic [mcps_pkg::ACC_W-1:0]       sum_add;
    logic                             hit;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Load words write the table memory directly; the start vector sits in
    // the extra row above the transition rows.
    assign wr_en  = accept && ((cmd.action == mcps_pkg::ACT_LOAD_START)
                            || (cmd.action == mcps_pkg::ACT_LOAD_TRANS));
    assign wr_row = (cmd.action == mcps_pkg::ACT_LOAD_START) ? mcps_pkg::START_ROW
                  : mcps_pkg::ROW_W'(cmd.row_index);
    assign wr_addr = {wr_row, mcps_pkg::IDX_W'(cmd.column_index)};
    assign rd_addr = {row_reg, rd_idx_reg};

    mcps_ram #(
        .WIDTH (mcps_pkg::PROB_BITS),
        .DEPTH (mcps_pkg::DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (cmd.probability),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Index of the last state in use, with the register clamped to 1..MAX_STATES.
    always_comb
    begin
        if (num_states_reg == '0)
        begin
            last_idx = '0;
        end
        else if (num_states_reg > mcps_pkg::CFG_W'(mcps_pkg::MAX_STATES))
        begin
            last_idx = mcps_pkg::IDX_W'(mcps_pkg::MAX_STATES - 1);
        end
        else
        begin
            last_idx = mcps_pkg::IDX_W'(num_states_reg - 1'b1);
        end
    end

    // Shared adder and compare: the running sum against the uniform word.
    assign sum_add = sum_reg + mcps_pkg::ACC_W'(rd_data);
    assign hit     = (sum_add >= mcps_pkg::ACC_W'(u_reg));

    // Sequencer: issue one read a cycle and retire one entry a cycle.
    always_comb
    begin
        state_next     = state_reg;
        cur_state_next = cur_state_reg;
        row_next       = row_reg;
        u_next         = u_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        vld_next       = vld_reg;
        sum_next       = sum_reg;
        done_next      = 1'b0;
        result_next    = result_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && ((cmd.action == mcps_pkg::ACT_STEP)
                            || (cmd.action == mcps_pkg::ACT_FIRST)))
                begin
                    state_next   = S_WALK;
                    row_next     = (cmd.action == mcps_pkg::ACT_FIRST) ? mcps_pkg::START_ROW
                                 : mcps_pkg::ROW_W'(cur_state_reg);
                    u_next       = cmd.uniform_sample;
                    rd_idx_next  = '0;
                    cmp_idx_next = '0;
                    vld_next     = 1'b0;
                    sum_next     = '0;
                end
            end
            S_WALK:
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
                vld_next    = 1'b1;
                if (vld_reg)
                begin
                    sum_next     = sum_add;
                    cmp_idx_next = cmp_idx_reg + 1'b1;
                    if (hit || (cmp_idx_reg == last_idx))
                    begin
                        state_next                = S_IDLE;
                        vld_next                  = 1'b0;
                        done_next                 = 1'b1;
                        cur_state_next            = hit ? cmp_idx_reg : last_idx;
                        result_next.sampled_state = 5'(cur_state_next) + 5'd1;
                        result_next.not_found     = !hit;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, configuration and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            num_states_reg <= mcps_pkg::CFG_W'(mcps_pkg::MAX_STATES);
            cur_state_reg  <= '0;
            vld_reg        <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_state_reg <= cur_state_next;
            vld_reg       <= vld_next;
            done_reg      <= done_next;
            if (cfg_we)
            begin
                num_states_reg <= cfg_wdata;
            end
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        row_reg     <= row_next;
        u_reg       <= u_next;
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        sum_reg     <= sum_next;
        result_reg  <= result_next;
    end

endmodule

// ===== design/mcps_ram.sv =====
module mcps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/markov_chain_path_sampler_test.sv =====
module markov_chain_path_sampler_test;
    import mcps_pkg::*;

    // Row of the local table copy that holds the start vector.
    localparam int START_SLOT    = MAX_STATES;
    // Wait after the last expected result; this covers any word still in flight.
    localparam int SETTLE_CYCLES = MAX_STATES + 4;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASE_WORDS   = 45;
    localparam int REPORT_LIMIT  = 10;

    typedef struct {
        cmd_t    word;
        bit      typed;
        result_t want;
    } directed_row_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    cmd_t             cmd;
    logic             done;
    result_t          result;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    // Local copy of the chain: probability tables, which entries have been
    // written, the current state and the state count register.
    logic [PROB_BITS-1:0] chain_tbl [0:MAX_STATES][0:MAX_STATES-1];
    bit                   loaded    [0:MAX_STATES][0:MAX_STATES-1];
    logic [IDX_W-1:0]     cur_state;
    logic [CFG_W-1:0]     num_states_cfg;

    result_t       expected_picks[$];
    directed_row_t directed_rows[$];
    int            mismatches;
    int            cycle_count;
    int            burst_left;
    int            phase_settings [0:9] = '{16, 1, 0, 31, 6, 17, 3, 16, 10, 2};

    markov_chain_path_sampler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Guard against a hung handshake.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Number of states the walk really covers once the register is clamped.
    function automatic int active_states();
        if (num_states_cfg == 0)
            return 1;
        if (num_states_cfg > MAX_STATES)
            return MAX_STATES;
        return int'(num_states_cfg);
    endfunction

    // True when every entry that a walk of this row may read has been written.
    function automatic bit row_ready(input int slot);
        int h;
        for (h = 0; h < active_states(); h++)
            if (!loaded[slot][h])
                return 1'b0;
        return 1'b1;
    endfunction

    // One probability draw in three is scaled to the state count so that walks end
    // anywhere along the row and sometimes run off its end.
    function automatic logic [PROB_BITS-1:0] random_prob();
        int top;
        top = (2 * (1 << PROB_BITS)) / active_states();
        if (top > (1 << PROB_BITS) - 1)
            top = (1 << PROB_BITS) - 1;
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return PROB_BITS'($urandom_range(0, top));
            default: return PROB_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [PROB_BITS-1:0] random_uniform();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return PROB_BITS'($urandom_range(0, 255));
            default: return PROB_BITS'($urandom);
        endcase
    endfunction

    task automatic record_failure(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s", $time, msg);
    endtask

    // Apply one accepted word to the local chain and work out its result.
    task automatic advance_chain_model(input cmd_t w, output bit makes, output result_t r);
        int               slot;
        int               n;
        int               h;
        int               pick;
        logic [ACC_W-1:0] sum;
        bit               miss;
        makes = 1'b0;
        r     = '0;
        case (w.action)
            ACT_LOAD_START:
            begin
                chain_tbl[START_SLOT][w.column_index] = w.probability;
                loaded[START_SLOT][w.column_index]    = 1'b1;
            end
            ACT_LOAD_TRANS:
            begin
                chain_tbl[w.row_index][w.column_index] = w.probability;
                loaded[w.row_index][w.column_index]    = 1'b1;
            end
            default:
            begin
                slot = (w.action == ACT_FIRST) ? START_SLOT : int'(cur_state);
                n    = active_states();
                sum  = '0;
                miss = 1'b1;
                pick = n - 1;
                for (h = 0; h < n; h++)
                begin
                    if (miss)
                    begin
                        sum = sum + chain_tbl[slot][h];
                        if (sum >= w.uniform_sample)
                        begin
                            pick = h;
                            miss = 1'b0;
                        end
                    end
                end
                cur_state       = IDX_W'(pick);
                r.sampled_state = 5'(pick + 1);
                r.not_found     = miss;
                makes           = 1'b1;
            end
        endcase
    endtask

    // Offer one word, with a gap in front of it at the start of most bursts.
    task automatic drive_word(input cmd_t w, input bit typed, input result_t want);
        int      gap;
        bit      makes;
        result_t got;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 12);
        end
        burst_left--;
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        cmd   <= w;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        advance_chain_model(w, makes, got);
        if (makes)
            expected_picks.push_back(typed ? want : got);
    endtask

    // Stop offering words and wait until the block has gone quiet.
    task automatic settle_block();
        @(negedge clk);
        start <= 1'b0;
        while (expected_picks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_num_states(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        num_states_cfg = value;
    endtask

    task automatic add_row(input action_t act, input int row, input int col, input int prob,
                           input int u, input bit typed, input int st, input bit nf);
        directed_row_t d;
        d.word.action         = act;
        d.word.row_index      = 4'(row);
        d.word.column_index   = 4'(col);
        d.word.probability    = PROB_BITS'(prob);
        d.word.uniform_sample = PROB_BITS'(u);
        d.typed               = typed;
        d.want.sampled_state  = 5'(st);
        d.want.not_found      = nf;
        directed_rows.push_back(d);
    endtask

    // Every result word is checked against the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_picks.size() == 0)
                record_failure($sformatf("unexpected result: state %0d not_found %0b",
                                         result.sampled_state, result.not_found));
            else
            begin
                want = expected_picks.pop_front();
                if (result.sampled_state !== want.sampled_state
                    || result.not_found !== want.not_found)
                    record_failure($sformatf(
                        "mismatch: expected state %0d not_found %0b, got state %0d not_found %0b",
                        want.sampled_state, want.not_found,
                        result.sampled_state, result.not_found));
            end
        end
    end

    initial
    begin
        cmd_t    w;
        result_t none;
        int      i;
        int      k;
        int      ph;
        int      slot;
        int      pick;
        int      c;

        start          = 1'b0;
        cmd            = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        rst_n          = 1'b0;
        mismatches     = 0;
        burst_left     = 0;
        none           = '0;
        cur_state      = '0;
        num_states_cfg = CFG_W'(MAX_STATES);
        for (i = 0; i <= MAX_STATES; i++)
            for (k = 0; k < MAX_STATES; k++)
            begin
                chain_tbl[i][k] = '0;
                loaded[i][k]    = 1'b0;
            end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part on a two-state chain.
        write_num_states(CFG_W'(2));
        add_row(ACT_LOAD_START, 9, 0, 16'h4000, 16'hFFFF, 1'b0, 0, 1'b0);
        add_row(ACT_LOAD_START, 0, 1, 16'h4000, 16'h0000, 1'b0, 0, 1'b0);
        add_row(ACT_LOAD_TRANS, 0, 0, 16'h0000, 16'h1111, 1'b0, 0, 1'b0);
        add_row(ACT_LOAD_TRANS, 0, 1, 16'hFFFF, 16'h2222, 1'b0, 0, 1'b0);
        add_row(ACT_LOAD_TRANS, 1, 0, 16'hFFFF, 16'h3333, 1'b0, 0, 1'b0);
        add_row(ACT_LOAD_TRANS, 1, 1, 16'hFFFF, 16'h4444, 1'b0, 0, 1'b0);
        // A plain step straight after reset walks row zero.
        add_row(ACT_STEP,       15, 15, 16'hFFFF, 16'h0001, 1'b1, 2, 1'b0);
        // A zero uniform always picks the first state.
        add_row(ACT_FIRST,      0, 0, 16'h0000, 16'h0000, 1'b1, 1, 1'b0);
        add_row(ACT_FIRST,      3, 7, 16'h1234, 16'h4000, 1'b0, 0, 1'b0);
        add_row(ACT_FIRST,      5, 2, 16'h8765, 16'h4001, 1'b0, 0, 1'b0);
        // The sum falls short: flag raised and the last state chosen.
        add_row(ACT_FIRST,      0, 0, 16'h0000, 16'hFFFF, 1'b1, 2, 1'b1);
        add_row(ACT_STEP,       0, 0, 16'h0000, 16'hFFFF, 1'b0, 0, 1'b0);
        add_row(ACT_STEP,       15, 0, 16'hFFFF, 16'hFFFF, 1'b0, 0, 1'b0);
        add_row(ACT_LOAD_TRANS, 15, 15, 16'hAAAA, 16'h5555, 1'b0, 0, 1'b0);
        add_row(ACT_LOAD_TRANS, 0, 0, 16'h5555, 16'hAAAA, 1'b0, 0, 1'b0);
        add_row(ACT_LOAD_START, 15, 15, 16'hFFFF, 16'h0000, 1'b0, 0, 1'b0);
        add_row(ACT_STEP,       6, 9, 16'h0F0F, 16'h1234, 1'b0, 0, 1'b0);
        add_row(ACT_STEP,       0, 0, 16'hF0F0, 16'h5555, 1'b0, 0, 1'b0);
        add_row(ACT_STEP,       0, 0, 16'h0000, 16'h5556, 1'b0, 0, 1'b0);
        add_row(ACT_LOAD_START, 0, 0, 16'h0000, 16'hFFFF, 1'b0, 0, 1'b0);
        add_row(ACT_LOAD_START, 0, 1, 16'h0000, 16'hFFFF, 1'b0, 0, 1'b0);
        add_row(ACT_FIRST,      0, 0, 16'h0000, 16'h0001, 1'b1, 2, 1'b1);
        add_row(ACT_FIRST,      0, 0, 16'h0000, 16'h0000, 1'b1, 1, 1'b0);
        for (i = 0; i < directed_rows.size(); i++)
            drive_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

        // Random part, one phase per state count setting.
        for (ph = 0; ph < 10; ph++)
        begin
            settle_block();
            write_num_states(CFG_W'(phase_settings[ph]));
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                w.action         = ACT_LOAD_START;
                w.row_index      = 4'($urandom);
                w.column_index   = 4'($urandom);
                w.probability    = random_prob();
                w.uniform_sample = random_uniform();
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    // Sample, or first fill the row that the walk would read.
                    slot = (pick < 20) ? START_SLOT : int'(cur_state);
                    if (row_ready(slot))
                        w.action = (slot == START_SLOT) ? ACT_FIRST : ACT_STEP;
                    else
                    begin
                        c = 0;
                        while (loaded[slot][c])
                            c++;
                        w.column_index = 4'(c);
                        if (slot == START_SLOT)
                            w.action = ACT_LOAD_START;
                        else
                        begin
                            w.action    = ACT_LOAD_TRANS;
                            w.row_index = 4'(slot);
                        end
                    end
                end
                else if (pick < 85)
                    w.action = ($urandom_range(0, 1) != 0) ? ACT_LOAD_TRANS : ACT_LOAD_START;
                else
                begin
                    // Rewrite an entry that the next walk may read.
                    w.column_index = 4'($urandom_range(0, active_states() - 1));
                    if (pick < 92)
                        w.action = ACT_LOAD_START;
                    else
                    begin
                        w.action    = ACT_LOAD_TRANS;
                        w.row_index = cur_state;
                    end
                end
                drive_word(w, 1'b0, none);
            end
        end

        settle_block();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== markov_chain_path_sampler.f =====
design/mcps_pkg.sv
design/mcps_ram.sv
design/markov_chain_path_sampler.sv
tb/markov_chain_path_sampler_test.sv
